### hdl/lmb_pkg.sv
`default_nettype none

package lmb_pkg;

    // result and data widths fixed by the stream format
    localparam int POS_W   = 10;
    localparam int ZONE_W  = 2;
    localparam int DB_W    = 13;
    localparam int CFG_W   = 16;
    localparam int IN_W    = 17;
    localparam int NUM_W   = 22;
    localparam int DEN_W   = 12;

    localparam int PEAK_FALL_Q16  = 62259;
    localparam int HOLD_DECAY_Q16 = 64881;
    localparam int OCTAVE_DB16    = 963;

    // register indexes
    localparam logic [2:0] REG_SMOOTH    = 3'd0;
    localparam logic [2:0] REG_MIN_DB    = 3'd1;
    localparam logic [2:0] REG_MAX_DB    = 3'd2;
    localparam logic [2:0] REG_YELLOW_DB = 3'd3;
    localparam logic [2:0] REG_RED_DB    = 3'd4;
    localparam logic [2:0] REG_SHOW_HOLD = 3'd5;
    localparam logic [2:0] REG_SHOW_RMS  = 3'd6;
    localparam logic [2:0] REG_BAR_LEN   = 3'd7;

    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [ZONE_W-1:0] ZONE_GREEN  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_YELLOW = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_RED    = 2'd2;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [POS_W-1:0]  quot;
    } t_div_rsp;

    // 200*log10(1 + i/16) in 1/16 tenths of dB
    function automatic logic [9:0] log_tab(input logic [4:0] idx);
        logic [9:0] v;
        case (idx)
            5'd0:    v = 10'd0;
            5'd1:    v = 10'd84;
            5'd2:    v = 10'd164;
            5'd3:    v = 10'd239;
            5'd4:    v = 10'd310;
            5'd5:    v = 10'd378;
            5'd6:    v = 10'd443;
            5'd7:    v = 10'd504;
            5'd8:    v = 10'd563;
            5'd9:    v = 10'd620;
            5'd10:   v = 10'd675;
            5'd11:   v = 10'd727;
            5'd12:   v = 10'd778;
            5'd13:   v = 10'd826;
            5'd14:   v = 10'd874;
            5'd15:   v = 10'd919;
            5'd16:   v = 10'd963;
            default: v = 10'd963;
        endcase
        return v;
    endfunction

    function automatic logic [ZONE_W-1:0] zone_of(
        input logic signed [DB_W-1:0] db,
        input logic signed [11:0]     yellow,
        input logic signed [11:0]     red
    );
        logic [ZONE_W-1:0] z;
        if (db >= DB_W'(red)) begin
            z = ZONE_RED;
        end else if (db >= DB_W'(yellow)) begin
            z = ZONE_YELLOW;
        end else begin
            z = ZONE_GREEN;
        end
        return z;
    endfunction

endpackage

`default_nettype wire

### hdl/lmb_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; quotient known to fit POS_W bits
module lmb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lmb_pkg::t_div_req i_req,
    output lmb_pkg::t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(lmb_pkg::POS_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [lmb_pkg::NUM_W-1:0]  r_rem;
    logic [lmb_pkg::NUM_W-1:0]  r_d;
    logic [lmb_pkg::POS_W-1:0]  r_q;
    logic                       w_ge;

    assign w_ge = (r_rem >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_d   <= lmb_pkg::NUM_W'({i_req.den, (lmb_pkg::POS_W - 1)'(0)});
            r_q   <= '0;
            r_cnt <= CNT_W'(lmb_pkg::POS_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_d;
            end
            r_q   <= {r_q[lmb_pkg::POS_W-2:0], w_ge};
            r_d   <= r_d >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

### hdl/level_meter_ballistics_core.sv
// level meter ballistics with peak hold
// input stream: s_axis_tuser is the function (0 set targets, 1 display tick),
// s_axis_tdata carries the signed rms and peak targets. every word gives one
// result word on the master side: rms, peak and hold bar positions, peak and
// hold zones in tdata, and the refresh flag in m_axis_tuser.
// one word is worked at a time through a small sequencer around one shared
// registered multiplier and a bit-serial divider. a tick first updates the
// levels, then runs three level-to-bar conversions; one that needs a divide
// goes through leading-one search in log steps, table interpolation, scale
// multiply and the divider. a level outside the meter range skips the divide,
// and a zero level is set to the bottom of the range directly. a set word runs
// the three conversions only; the next word is accepted once the block is back
// in idle. s_axis_tready is high only while the block is idle. the result sits
// in an output register; if the receiver stalls, the next word is still
// accepted and worked, and the block waits before its own result register
// until the old one is taken. reset (synchronous, active low) clears all
// levels, the hold counter and the result valid flag and loads the register
// defaults. config writes are taken in any cycle and belong only to idle
// periods.
`default_nettype none

module level_meter_ballistics_core #(
    parameter int LEVEL_FRAC_BITS = 15,
    parameter int HOLD_TICKS      = 60
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // rms_level[16:0], peak_level[33:17], zero fill
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // rms_position[9:0], peak_position[19:10],
                                            // hold_position[29:20], peak_zone[31:30],
                                            // hold_zone[33:32], zero fill
    output logic             m_axis_tuser,  // refresh
    input  wire logic        i_cfg_we,
    input  wire logic  [2:0] i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int LW     = LEVEL_FRAC_BITS + 1;
    localparam int SW     = $clog2(LW);
    localparam int MA_W   = (LW > lmb_pkg::DB_W) ? LW : lmb_pkg::DB_W;
    localparam int MB_W   = 17;
    localparam int PW     = MA_W + MB_W;
    localparam int CW     = ((LW > lmb_pkg::IN_W) ? LW : lmb_pkg::IN_W) + 1;
    localparam int ONE_I  = 1 << LEVEL_FRAC_BITS;
    localparam int THRESH = (ONE_I + 500) / 1000;
    localparam logic [LW-1:0] ONE = LW'(ONE_I);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RMS    = 4'd1;
    localparam logic [3:0] ST_RMS_W  = 4'd2;
    localparam logic [3:0] ST_PK     = 4'd3;
    localparam logic [3:0] ST_PK_W   = 4'd4;
    localparam logic [3:0] ST_HOLD   = 4'd5;
    localparam logic [3:0] ST_HOLD_W = 4'd6;
    localparam logic [3:0] ST_LOAD   = 4'd7;
    localparam logic [3:0] ST_NORM   = 4'd8;
    localparam logic [3:0] ST_INTERP = 4'd9;
    localparam logic [3:0] ST_DB     = 4'd10;
    localparam logic [3:0] ST_POS    = 4'd11;
    localparam logic [3:0] ST_POS_W  = 4'd12;
    localparam logic [3:0] ST_DIV    = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;

    // configuration
    logic [15:0]        r_smooth;
    logic signed [11:0] r_min_db;
    logic signed [11:0] r_max_db;
    logic signed [11:0] r_yellow_db;
    logic signed [11:0] r_red_db;
    logic               r_show_hold;
    logic               r_show_rms;
    logic [9:0]         r_bar_len;

    // ballistics state
    logic [3:0]     r_state;
    logic [LW-1:0]  r_rms_tgt;
    logic [LW-1:0]  r_pk_tgt;
    logic [LW-1:0]  r_rms_now;
    logic [LW-1:0]  r_pk_now;
    logic [LW-1:0]  r_hold_lvl;
    logic [7:0]     r_hold_cnt;
    logic           r_refresh;

    // conversion
    logic [1:0]                    r_k;
    logic [LW-1:0]                 r_norm;
    logic [SW-1:0]                 r_sh;
    logic [SW-1:0]                 r_step;
    logic signed [lmb_pkg::DB_W-1:0] r_db_cur;
    logic signed [lmb_pkg::DB_W-1:0] r_db [3];
    logic [lmb_pkg::POS_W-1:0]     r_pos [3];
    logic [PW-1:0]                 r_prod;

    logic        r_m_valid;
    logic [39:0] r_m_data;
    logic        r_m_user;

    logic [MA_W-1:0]   w_mul_a;
    logic [MB_W-1:0]   w_mul_b;
    lmb_pkg::t_div_req w_div_req;
    lmb_pkg::t_div_rsp w_div_rsp;

    logic signed [CW-1:0] w_rms_in;
    logic signed [CW-1:0] w_pk_in;
    logic [LW-1:0]        w_rms_clamp;
    logic [LW-1:0]        w_pk_clamp;
    logic                 w_rms_up;
    logic [LW-1:0]        w_rms_diff;
    logic [LW-1:0]        w_pk_gap;
    logic [LW-1:0]        w_level;
    logic [LW-1:0]        w_step_amt;
    logic                 w_top_zero;
    logic [LW+15:0]       w_ext;
    logic [15:0]          w_norm16;
    logic [4:0]           w_idx;
    logic [10:0]          w_frac;
    logic [9:0]           w_delta;
    logic [14:0]          w_val;
    logic [14:0]          w_neg;
    logic [14:0]          w_rnd;
    logic signed [lmb_pkg::DB_W-1:0] w_db;
    logic signed [lmb_pkg::DB_W-1:0] w_min_x;
    logic signed [lmb_pkg::DB_W-1:0] w_max_x;
    logic signed [lmb_pkg::DB_W:0]   w_db_off;
    logic [PW:0]          w_round16;
    logic [LW-1:0]        w_step_rnd;
    logic                 w_out_free;
    logic [lmb_pkg::POS_W-1:0] w_rms_pos;
    logic [lmb_pkg::POS_W-1:0] w_hold_pos;
    logic [lmb_pkg::ZONE_W-1:0] w_pk_zone;
    logic [lmb_pkg::ZONE_W-1:0] w_hold_zone;

    lmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // target clamping to 0..1.0
    always_comb begin
        w_rms_in = CW'($signed(s_axis_tdata[16:0]));
        w_pk_in  = CW'($signed(s_axis_tdata[33:17]));
        if (w_rms_in <= 0) begin
            w_rms_clamp = '0;
        end else if (w_rms_in > $signed(CW'(ONE))) begin
            w_rms_clamp = ONE;
        end else begin
            w_rms_clamp = LW'(w_rms_in);
        end
        if (w_pk_in <= 0) begin
            w_pk_clamp = '0;
        end else if (w_pk_in > $signed(CW'(ONE))) begin
            w_pk_clamp = ONE;
        end else begin
            w_pk_clamp = LW'(w_pk_in);
        end
    end

    always_comb begin
        w_rms_up   = (r_rms_tgt >= r_rms_now);
        w_rms_diff = w_rms_up ? (r_rms_tgt - r_rms_now) : (r_rms_now - r_rms_tgt);
        w_pk_gap   = r_pk_now - r_pk_tgt;
        w_round16  = (PW + 1)'(r_prod) + (PW + 1)'(32768);
        w_step_rnd = LW'(w_round16 >> 16);
        case (r_k)
            2'd0:    w_level = r_rms_now;
            2'd1:    w_level = r_pk_now;
            default: w_level = r_hold_lvl;
        endcase
    end

    // leading-one search in halving steps, then table interpolation
    always_comb begin
        w_step_amt = LW'(1) << r_step;
        w_top_zero = ((r_norm >> (LW'(LW) - w_step_amt)) == '0);
        w_ext      = {r_norm, 16'b0};
        w_norm16   = w_ext[LW+15 -: 16];
        w_idx      = {1'b0, w_norm16[14:11]};
        w_frac     = w_norm16[10:0];
        w_delta    = lmb_pkg::log_tab(w_idx + 5'd1) - lmb_pkg::log_tab(w_idx);
        w_val      = 15'(lmb_pkg::log_tab(w_idx))
                   + 15'((r_prod[18:0] + 19'd1024) >> 11);
        w_neg      = 15'(r_sh) * 15'(lmb_pkg::OCTAVE_DB16) - w_val;
        w_rnd      = (w_neg + 15'd8) >> 4;
        w_db       = -$signed(lmb_pkg::DB_W'(w_rnd));
        w_min_x    = lmb_pkg::DB_W'(r_min_db);
        w_max_x    = lmb_pkg::DB_W'(r_max_db);
        w_db_off   = (lmb_pkg::DB_W + 1)'(r_db_cur) - (lmb_pkg::DB_W + 1)'(w_min_x);
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            ST_RMS: begin
                w_mul_a = MA_W'(w_rms_diff);
                w_mul_b = MB_W'(17'h10000 - 17'(r_smooth));
            end
            ST_PK: begin
                w_mul_a = MA_W'(w_pk_gap);
                w_mul_b = MB_W'(lmb_pkg::PEAK_FALL_Q16);
            end
            ST_HOLD: begin
                w_mul_a = MA_W'(r_hold_lvl);
                w_mul_b = MB_W'(lmb_pkg::HOLD_DECAY_Q16);
            end
            ST_INTERP: begin
                w_mul_a = MA_W'(w_delta);
                w_mul_b = MB_W'(w_frac);
            end
            ST_POS: begin
                w_mul_a = MA_W'(unsigned'(w_db_off));
                w_mul_b = MB_W'(r_bar_len);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_mul_a) * PW'(w_mul_b);
    end

    assign w_div_req.start = (r_state == ST_POS_W);
    assign w_div_req.num   = lmb_pkg::NUM_W'(r_prod);
    assign w_div_req.den   = lmb_pkg::DEN_W'(w_max_x - w_min_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth    <= 16'd52429;
            r_min_db    <= -12'sd600;
            r_max_db    <= 12'sd0;
            r_yellow_db <= -12'sd120;
            r_red_db    <= -12'sd60;
            r_show_hold <= 1'b1;
            r_show_rms  <= 1'b1;
            r_bar_len   <= 10'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lmb_pkg::REG_SMOOTH:    r_smooth    <= i_cfg_wdata;
                lmb_pkg::REG_MIN_DB:    r_min_db    <= i_cfg_wdata[11:0];
                lmb_pkg::REG_MAX_DB:    r_max_db    <= i_cfg_wdata[11:0];
                lmb_pkg::REG_YELLOW_DB: r_yellow_db <= i_cfg_wdata[11:0];
                lmb_pkg::REG_RED_DB:    r_red_db    <= i_cfg_wdata[11:0];
                lmb_pkg::REG_SHOW_HOLD: r_show_hold <= i_cfg_wdata[0];
                lmb_pkg::REG_SHOW_RMS:  r_show_rms  <= i_cfg_wdata[0];
                lmb_pkg::REG_BAR_LEN:   r_bar_len   <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        w_rms_pos   = (r_show_rms && r_rms_now != '0) ? r_pos[0] : '0;
        w_hold_pos  = r_show_hold ? r_pos[2] : '0;
        w_pk_zone   = lmb_pkg::zone_of(r_db[1], r_yellow_db, r_red_db);
        w_hold_zone = r_show_hold ? lmb_pkg::zone_of(r_db[2], r_yellow_db, r_red_db)
                                  : lmb_pkg::ZONE_GREEN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rms_tgt  <= '0;
            r_pk_tgt   <= '0;
            r_rms_now  <= '0;
            r_pk_now   <= '0;
            r_hold_lvl <= '0;
            r_hold_cnt <= '0;
            r_refresh  <= 1'b0;
            r_k        <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_k       <= '0;
                    r_refresh <= 1'b0;
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == lmb_pkg::FUNC_SET) begin
                            r_rms_tgt <= w_rms_clamp;
                            r_pk_tgt  <= w_pk_clamp;
                            r_state   <= ST_LOAD;
                        end else begin
                            r_state   <= ST_RMS;
                        end
                    end
                end
                ST_RMS: begin
                    r_state <= (w_rms_diff > LW'(THRESH)) ? ST_RMS_W : ST_PK;
                end
                ST_RMS_W: begin
                    r_rms_now <= w_rms_up ? (r_rms_now + w_step_rnd) : (r_rms_now - w_step_rnd);
                    r_refresh <= 1'b1;
                    r_state   <= ST_PK;
                end
                ST_PK: begin
                    if (r_pk_tgt > r_pk_now) begin
                        r_pk_now  <= r_pk_tgt;
                        r_refresh <= 1'b1;
                        r_state   <= ST_HOLD;
                    end else if (r_pk_now > r_pk_tgt) begin
                        r_state   <= ST_PK_W;
                    end else begin
                        r_state   <= ST_HOLD;
                    end
                end
                ST_PK_W: begin
                    r_pk_now  <= r_pk_now - w_step_rnd;
                    r_refresh <= 1'b1;
                    r_state   <= ST_HOLD;
                end
                ST_HOLD: begin
                    r_state <= ST_LOAD;
                    if (r_show_hold) begin
                        if (r_pk_now > r_hold_lvl) begin
                            r_hold_lvl <= r_pk_now;
                            r_hold_cnt <= 8'(HOLD_TICKS);
                        end else if (r_hold_cnt != '0) begin
                            r_hold_cnt <= r_hold_cnt - 1'b1;
                        end else begin
                            r_state <= ST_HOLD_W;
                        end
                    end
                end
                ST_HOLD_W: begin
                    r_hold_lvl <= LW'(r_prod >> 16);
                    r_refresh  <= 1'b1;
                    r_state    <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_norm <= w_level;
                    r_sh   <= '0;
                    r_step <= SW'(SW - 1);
                    if (w_level == '0) begin
                        // silent level sits at the bottom of the range
                        r_db[r_k]  <= w_min_x;
                        r_pos[r_k] <= '0;
                        r_k        <= r_k + 1'b1;
                        r_state    <= (r_k == 2'd2) ? ST_FIN : ST_LOAD;
                    end else begin
                        r_state    <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (w_top_zero) begin
                        r_norm <= r_norm << w_step_amt;
                        r_sh   <= r_sh + SW'(w_step_amt);
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_INTERP;
                    end
                end
                ST_INTERP: begin
                    r_state <= ST_DB;
                end
                ST_DB: begin
                    r_db_cur <= w_db;
                    r_state  <= ST_POS;
                end
                ST_POS: begin
                    r_db[r_k] <= r_db_cur;
                    if (r_db_cur <= w_min_x) begin
                        r_pos[r_k] <= '0;
                        r_k        <= r_k + 1'b1;
                        r_state    <= (r_k == 2'd2) ? ST_FIN : ST_LOAD;
                    end else if (r_db_cur >= w_max_x) begin
                        r_pos[r_k] <= r_bar_len;
                        r_k        <= r_k + 1'b1;
                        r_state    <= (r_k == 2'd2) ? ST_FIN : ST_LOAD;
                    end else begin
                        r_state    <= ST_POS_W;
                    end
                end
                ST_POS_W: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_pos[r_k] <= w_div_rsp.quot;
                        r_k        <= r_k + 1'b1;
                        r_state    <= (r_k == 2'd2) ? ST_FIN : ST_LOAD;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_m_data <= {6'b0, w_hold_zone, w_pk_zone, w_hold_pos, r_pos[1], w_rms_pos};
            r_m_user <= r_refresh;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

### hdl/lmb_checker.sv
`default_nettype none

module lmb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // a stalled result word keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // one word at a time: the input closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after accept");

    // zones are green, yellow or red only
    a_zone_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:30] != 2'd3 && m_axis_tdata[33:32] != 2'd3)
        else $error("bad zone code");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind level_meter_ballistics_core lmb_checker u_lmb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/level_meter_checker.sv
`default_nettype none

module level_meter_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic  [2:0] i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 15;
    localparam int ONE = 1 << FRAC;
    localparam int THRESH = (ONE + 500) / 1000;
    localparam int HOLD = 60;

    typedef struct packed {
        logic [9:0] rms_pos;
        logic [9:0] peak_pos;
        logic [9:0] hold_pos;
        logic [1:0] peak_zn;
        logic [1:0] hold_zn;
        logic       refresh;
    } t_meter_word;

    int db_curve [17] = '{0, 84, 164, 239, 310, 378, 443, 504, 563,
                          620, 675, 727, 778, 826, 874, 919, 963};

    int smooth, lo_db, hi_db, yel_db, red_db, bar_len;
    bit hold_on, rms_on;
    int rms_tgt, peak_tgt, rms_lvl, peak_lvl, hold_lvl, hold_cnt;
    t_meter_word bars_due [$];

    function automatic int to_db(input int level);
        int p, norm, f, idx, rem, val, neg;
        if (level == 0) return lo_db;
        p = 0;
        while (p < 31 && (level >> (p + 1)) != 0) p++;
        norm = (p <= 15) ? (level << (15 - p)) : (level >> (p - 15));
        f = norm - 32768;
        idx = (f >> 11) & 15;
        rem = f & 2047;
        val = db_curve[idx] + (((db_curve[idx + 1] - db_curve[idx]) * rem + 1024) >> 11);
        neg = (FRAC - p) * 963 - val;
        return -((neg + 8) >> 4);
    endfunction

    function automatic int to_pos(input int db);
        if (db <= lo_db) return 0;
        if (db >= hi_db) return bar_len;
        return ((db - lo_db) * bar_len / (hi_db - lo_db)) & 1023;
    endfunction

    function automatic logic [1:0] zone(input int db);
        if (db >= red_db) return lmb_pkg::ZONE_RED;
        if (db >= yel_db) return lmb_pkg::ZONE_YELLOW;
        return lmb_pkg::ZONE_GREEN;
    endfunction

    function automatic int clamp_lvl(input logic signed [16:0] v);
        if (v <= 0) return 0;
        if (int'(v) > ONE) return ONE;
        return int'(v);
    endfunction

    function automatic t_meter_word advance_meter(input logic fn, input logic [39:0] d);
        t_meter_word r;
        longint diff, stp, gap;
        int pdb, hdb;
        r = '0;
        if (fn == lmb_pkg::FUNC_SET) begin
            rms_tgt = clamp_lvl(d[16:0]);
            peak_tgt = clamp_lvl(d[33:17]);
        end else begin
            diff = (rms_tgt >= rms_lvl) ? rms_tgt - rms_lvl : rms_lvl - rms_tgt;
            if (diff > THRESH) begin
                stp = (diff * (65536 - smooth) + 32768) >> 16;
                if (rms_tgt >= rms_lvl) rms_lvl += int'(stp);
                else rms_lvl -= int'(stp);
                r.refresh = 1'b1;
            end
            if (peak_tgt > peak_lvl) begin
                peak_lvl = peak_tgt;
                r.refresh = 1'b1;
            end else if (peak_lvl > peak_tgt) begin
                gap = peak_lvl - peak_tgt;
                peak_lvl -= int'((gap * 62259 + 32768) >> 16);
                r.refresh = 1'b1;
            end
            if (hold_on) begin
                if (peak_lvl > hold_lvl) begin
                    hold_lvl = peak_lvl;
                    hold_cnt = HOLD;
                end else if (hold_cnt > 0) begin
                    hold_cnt--;
                end else begin
                    hold_lvl = int'((longint'(hold_lvl) * 64881) >> 16);
                    r.refresh = 1'b1;
                end
            end
        end
        pdb = to_db(peak_lvl);
        hdb = to_db(hold_lvl);
        r.rms_pos = 10'((rms_on && rms_lvl > 0) ? to_pos(to_db(rms_lvl)) : 0);
        r.peak_pos = 10'(peak_lvl > 0 ? to_pos(pdb) : 0);
        r.hold_pos = 10'((hold_on && hold_lvl > 0) ? to_pos(hdb) : 0);
        r.peak_zn = zone(pdb);
        r.hold_zn = hold_on ? zone(hdb) : lmb_pkg::ZONE_GREEN;
        return r;
    endfunction

    t_meter_word got, want;

    assign o_pending = bars_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smooth <= 52429; lo_db <= -600; hi_db <= 0; yel_db <= -120; red_db <= -60;
            hold_on <= 1'b1; rms_on <= 1'b1; bar_len <= 256;
            rms_tgt = 0; peak_tgt = 0; rms_lvl = 0; peak_lvl = 0; hold_lvl = 0; hold_cnt = 0;
            bars_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lmb_pkg::REG_SMOOTH:    smooth <= int'(i_cfg_wdata);
                    lmb_pkg::REG_MIN_DB:    lo_db <= int'(signed'(i_cfg_wdata[11:0]));
                    lmb_pkg::REG_MAX_DB:    hi_db <= int'(signed'(i_cfg_wdata[11:0]));
                    lmb_pkg::REG_YELLOW_DB: yel_db <= int'(signed'(i_cfg_wdata[11:0]));
                    lmb_pkg::REG_RED_DB:    red_db <= int'(signed'(i_cfg_wdata[11:0]));
                    lmb_pkg::REG_SHOW_HOLD: hold_on <= i_cfg_wdata[0];
                    lmb_pkg::REG_SHOW_RMS:  rms_on <= i_cfg_wdata[0];
                    lmb_pkg::REG_BAR_LEN:   bar_len <= int'(i_cfg_wdata[9:0]);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                bars_due.push_back(advance_meter(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[29:20],
                       m_axis_tdata[31:30], m_axis_tdata[33:32], m_axis_tuser};
                if (bars_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = bars_due.pop_front();
                    if (got !== want || m_axis_tdata[39:34] !== 6'd0) begin
                        $display("%0t: mismatch expected rms %0d peak %0d hold %0d pz %0d hz %0d ref %0d",
                                 $time, want.rms_pos, want.peak_pos, want.hold_pos,
                                 want.peak_zn, want.hold_zn, want.refresh);
                        $display("%0t:          actual rms %0d peak %0d hold %0d pz %0d hz %0d ref %0d",
                                 $time, got.rms_pos, got.peak_pos, got.hold_pos,
                                 got.peak_zn, got.hold_zn, got.refresh);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 0;
    logic  [2:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          stall_mode = 0;

    always #4 i_clk = ~i_clk;

    level_meter_ballistics_core dut (.*);

    level_meter_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .o_errors(errors), .o_pending(pending)
    );

    // receiver: alternate between free-running and heavy stall stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    int gap_left = 0;

    // valid stays high between back-to-back words and drops only for a gap
    task automatic send_word(input logic fn, input logic signed [16:0] rms,
                             input logic signed [16:0] pk);
        if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
        if (gap_left > 0) s_axis_tvalid <= 0;
        while (gap_left > 0) begin
            @(posedge i_clk);
            gap_left--;
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {6'd0, pk, rms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic signed [16:0] any_level;
        case ($urandom_range(0, 5))
            0: return 17'sd0;
            1: return 17'sd32768;
            2: return 17'($urandom_range(0, 40));
            3: return -17'($urandom_range(1, 65536));
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_phase(input int n);
        int i, tk;
        for (i = 0; i < n; i++) begin
            send_word(lmb_pkg::FUNC_SET, any_level(), any_level());
            // run ticks long enough to reach the hold decay sometimes
            tk = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 6);
            repeat (tk) send_word(lmb_pkg::FUNC_TICK, 17'($urandom), 17'($urandom));
        end
    endtask

    task automatic set_range(input int lo, input int hi, input int yel, input int red,
                             input int bar);
        write_reg(lmb_pkg::REG_MIN_DB, 16'(lo));
        write_reg(lmb_pkg::REG_MAX_DB, 16'(hi));
        write_reg(lmb_pkg::REG_YELLOW_DB, 16'(yel));
        write_reg(lmb_pkg::REG_RED_DB, 16'(red));
        write_reg(lmb_pkg::REG_BAR_LEN, 16'(bar));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, silence, full scale, clamping
        send_word(lmb_pkg::FUNC_TICK, 17'sd0, 17'sd0);
        send_word(lmb_pkg::FUNC_SET, 17'sd65535, 17'h10000);
        send_word(lmb_pkg::FUNC_TICK, 17'sd0, 17'sd0);
        send_word(lmb_pkg::FUNC_SET, -17'sd1, 17'sd65535);
        send_word(lmb_pkg::FUNC_TICK, 17'sd0, 17'sd0);
        send_word(lmb_pkg::FUNC_SET, 17'sd32768, 17'sd1);
        repeat (5) send_word(lmb_pkg::FUNC_TICK, 17'h1FFFF, 17'h1FFFF);
        send_word(lmb_pkg::FUNC_SET, 17'sd33, 17'sd0);
        repeat (12) send_word(lmb_pkg::FUNC_TICK, 17'sd0, 17'sd0);
        drain();

        write_reg(lmb_pkg::REG_SMOOTH, 16'd0);
        write_reg(lmb_pkg::REG_SHOW_HOLD, 16'd0);
        write_reg(lmb_pkg::REG_SHOW_RMS, 16'd0);
        set_range(-1200, 200, -1200, 200, 1023);
        random_phase(12);
        drain();

        write_reg(lmb_pkg::REG_SMOOTH, 16'hFFFF);
        write_reg(lmb_pkg::REG_SHOW_HOLD, 16'd1);
        write_reg(lmb_pkg::REG_SHOW_RMS, 16'd1);
        set_range(200, -1200, 200, -1200, 1);
        random_phase(12);
        drain();

        // max equal to min, bar length zero
        set_range(-300, -300, -400, -100, 0);
        random_phase(10);
        drain();

        write_reg(lmb_pkg::REG_SMOOTH, 16'd52429);
        set_range(-600, 0, -120, -60, 256);
        random_phase(30);
        drain();

        write_reg(lmb_pkg::REG_SMOOTH, 16'($urandom));
        set_range(-$urandom_range(0, 1200), $urandom_range(0, 200), -$urandom_range(0, 600),
                  -$urandom_range(0, 100), $urandom_range(1, 1023));
        random_phase(24);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
